// ===== design/mas_pkg.sv =====
// Shared types, codes and helpers of the matrix add/subtract/multiply block.
package mas_pkg;

	localparam int MAX_DIM_DEF = 16;
	// Largest row or column count that the 4-bit index fields can reach.
	localparam int STORE_LIM   = 16;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
	localparam logic [1:0] FUNC_REQUEST = 2'd2;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_DIM = 2'd1;
	localparam logic [1:0] STAT_POS = 2'd2;

	localparam logic [2:0] REG_OP_MODE = 3'd0;
	localparam logic [2:0] REG_A_ROWS  = 3'd1;
	localparam logic [2:0] REG_A_COLS  = 3'd2;
	localparam logic [2:0] REG_B_ROWS  = 3'd3;
	localparam logic [2:0] REG_B_COLS  = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [15:0] value;
	} item_t;

	typedef struct packed {
		logic [3:0]         out_row;
		logic [3:0]         out_col;
		logic signed [35:0] result_value;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic [1:0] op_mode;
		logic [4:0] a_rows;
		logic [4:0] a_cols;
		logic [4:0] b_rows;
		logic [4:0] b_cols;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		op_mode: OP_ADD,
		a_rows:  5'd1,
		a_cols:  5'd1,
		b_rows:  5'd1,
		b_cols:  5'd1
	};

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDSUB,
		S_MAC,
		S_DONE
	} state_t;

	// A dimension is usable when it is nonzero and fits both limits.
	function automatic logic dim_ok(input logic [4:0] d, input int unsigned lim);
		return (d != 5'd0) && (32'(d) <= lim) && (32'(d) <= 32'(STORE_LIM));
	endfunction

endpackage

// ===== design/mas_cfg.sv =====
// APB-style configuration register file of the matrix block.
module mas_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mas_pkg::CFG_AW-1:0] paddr,
	input  logic [mas_pkg::CFG_DW-1:0] pwdata,
	output logic [mas_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	output mas_pkg::cfg_t               cfg
);
	import mas_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OP_MODE: cfg_q.op_mode <= pwdata[1:0];
				REG_A_ROWS:  cfg_q.a_rows  <= pwdata[4:0];
				REG_A_COLS:  cfg_q.a_cols  <= pwdata[4:0];
				REG_B_ROWS:  cfg_q.b_rows  <= pwdata[4:0];
				REG_B_COLS:  cfg_q.b_cols  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OP_MODE: prdata = CFG_DW'(cfg_q.op_mode);
			REG_A_ROWS:  prdata = CFG_DW'(cfg_q.a_rows);
			REG_A_COLS:  prdata = CFG_DW'(cfg_q.a_cols);
			REG_B_ROWS:  prdata = CFG_DW'(cfg_q.b_rows);
			REG_B_COLS:  prdata = CFG_DW'(cfg_q.b_cols);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== design/matrix_add_sub_mul.sv =====
// Top level of the matrix add/subtract/multiply block: element stores, sequencer, output.
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_stall     mas_pkg::item_t   (func, row, col, value)
//  result    out        result_valid / result_stall mas_pkg::result_t (row, col, value, status)
//  config    in         psel/penable/pwrite/pready  op_mode, a_rows, a_cols, b_rows, b_cols
//
// A load transaction writes the element store directly. A request with a dimension or
// position error goes straight to the done state; add/subtract reads one element pair;
// multiply reads a_cols pairs: the single read port of each store delivers one A/B
// element pair per cycle into one registered multiplier and one accumulator.
// Reset clears control state and the config registers; the element stores are not
// cleared and need no clearing pass, every element must be loaded before it is read.
// A finished result waits in the output register; while it waits, load transactions
// are still taken, and a following request runs until its own result needs the register.
module matrix_add_sub_mul #(
	parameter int MAX_DIM = mas_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mas_pkg::CFG_AW-1:0] paddr,
	input  logic [mas_pkg::CFG_DW-1:0] pwdata,
	output logic [mas_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	// input items
	input  logic                        item_valid,
	output logic                        item_stall,
	input  mas_pkg::item_t              item,
	// result items
	output logic                        result_valid,
	input  logic                        result_stall,
	output mas_pkg::result_t            result
);
	import mas_pkg::*;

	// Store geometry: rows and columns that can ever be written.
	localparam int SD    = (MAX_DIM < STORE_LIM) ? MAX_DIM : STORE_LIM;
	localparam int DEPTH = SD * SD;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cfg_t cfg;

	mas_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Element stores, one synchronous read and one write port each.
	logic signed [15:0] mem_a [DEPTH];
	logic signed [15:0] mem_b [DEPTH];

	state_t             state_q, state_d;
	logic [3:0]         row_q, col_q;
	logic [4:0]         n_q;        // terms of the dot product
	logic [4:0]         iss_q;      // next term to fetch
	logic [1:0]         stat_q;
	logic signed [35:0] acc_q;
	logic               rdv_s1;     // read data valid
	logic signed [15:0] rd_a_s1, rd_b_s1;
	logic               pv_s2;      // product valid
	logic signed [31:0] prod_s2;
	logic               result_valid_q;
	result_t            result_q;

	logic               item_acc, req_acc;
	logic               wr_a, wr_b, load_in_range;
	logic [AW-1:0]      waddr;
	logic [1:0]         req_status;
	logic [4:0]         res_rows, res_cols;
	logic               issue, res_load, mac_done;
	logic               rd_mul;
	logic [3:0]         rd_row, rd_col, rd_k;
	logic [AW-1:0]      raddr_a, raddr_b;

	assign item_acc = item_valid & ~item_stall;
	assign req_acc  = item_acc && (item.func == FUNC_REQUEST);

	// Loads outside the store are dropped.
	assign load_in_range = (int'(item.row) < SD) && (int'(item.col) < SD);
	assign wr_a  = item_acc && (item.func == FUNC_LOAD_A) && load_in_range;
	assign wr_b  = item_acc && (item.func == FUNC_LOAD_B) && load_in_range;
	assign waddr = AW'(int'(item.row) * SD + int'(item.col));

	// Request check: dimensions first, then position.
	always_comb begin
		req_status = STAT_OK;
		res_rows   = cfg.a_rows;
		res_cols   = cfg.a_cols;
		if (!dim_ok(cfg.a_rows, MAX_DIM) || !dim_ok(cfg.a_cols, MAX_DIM) ||
		    !dim_ok(cfg.b_rows, MAX_DIM) || !dim_ok(cfg.b_cols, MAX_DIM)) begin
			req_status = STAT_DIM;
		end else if (cfg.op_mode inside {OP_ADD, OP_SUB}) begin
			if (cfg.a_rows != cfg.b_rows || cfg.a_cols != cfg.b_cols) begin
				req_status = STAT_DIM;
			end
		end else if (cfg.op_mode == OP_MUL) begin
			if (cfg.a_cols != cfg.b_rows) begin
				req_status = STAT_DIM;
			end else begin
				res_cols = cfg.b_cols;
			end
		end else begin
			req_status = STAT_DIM;
		end
		if (req_status == STAT_OK &&
		    (5'(item.row) >= res_rows || 5'(item.col) >= res_cols)) begin
			req_status = STAT_POS;
		end
	end

	assign mac_done = (iss_q == n_q) && !rdv_s1 && !pv_s2;
	assign res_load = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (req_status != STAT_OK) begin
						state_d = S_DONE;
					end else if (cfg.op_mode == OP_MUL) begin
						state_d = S_MAC;
					end else begin
						state_d = S_ADDSUB;
					end
				end
			end
			S_ADDSUB: state_d = S_DONE;
			S_MAC: begin
				if (mac_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: stall and store read addressing.
	always_comb begin
		item_stall = 1'b1;
		issue      = 1'b0;
		rd_row     = item.row;
		rd_col     = item.col;
		rd_k       = '0;
		rd_mul     = (cfg.op_mode == OP_MUL);
		case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				issue      = req_acc && (req_status == STAT_OK);
			end
			S_MAC: begin
				rd_row = row_q;
				rd_col = col_q;
				rd_k   = iss_q[3:0];
				issue  = (iss_q < n_q);
			end
			default: ;
		endcase
	end

	// Multiply walks row rd_row of A against column rd_col of B; add/sub reads one element.
	assign raddr_a = rd_mul ? AW'(int'(rd_row) * SD + int'(rd_k))
	                        : AW'(int'(rd_row) * SD + int'(rd_col));
	assign raddr_b = rd_mul ? AW'(int'(rd_k) * SD + int'(rd_col))
	                        : AW'(int'(rd_row) * SD + int'(rd_col));

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[waddr] <= item.value;
		end
		if (issue) begin
			rd_a_s1 <= mem_a[raddr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[waddr] <= item.value;
		end
		if (issue) begin
			rd_b_s1 <= mem_b[raddr_b];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rdv_s1         <= 1'b0;
			pv_s2          <= 1'b0;
			iss_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= issue;
			pv_s2   <= rdv_s1 && (state_q == S_MAC);
			if (req_acc) begin
				iss_q <= 5'd1;
			end else if (state_q == S_MAC && issue) begin
				iss_q <= iss_q + 5'd1;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			row_q  <= item.row;
			col_q  <= item.col;
			n_q    <= cfg.a_cols;
			stat_q <= req_status;
			acc_q  <= '0;
		end else if (state_q == S_ADDSUB) begin
			if (cfg.op_mode == OP_SUB) begin
				acc_q <= 36'(rd_a_s1) - 36'(rd_b_s1);
			end else begin
				acc_q <= 36'(rd_a_s1) + 36'(rd_b_s1);
			end
		end else if (state_q == S_MAC && pv_s2) begin
			acc_q <= acc_q + {{4{prod_s2[31]}}, prod_s2};
		end
		if (rdv_s1) begin
			prod_s2 <= rd_a_s1 * rd_b_s1;
		end
		if (res_load) begin
			result_q <= '{
				out_row:      row_q,
				out_col:      col_q,
				result_value: acc_q,
				status:       stat_q
			};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== design/mas_chk.sv =====
// Port-level checker of the matrix block and its bind to the top level.
module mas_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input mas_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input mas_pkg::result_t result
);
	import mas_pkg::*;

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// An error result carries a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != STAT_OK) |-> (result.result_value == '0))
		else $error("error result with nonzero value");

	// An accepted request keeps the block busy in the next cycle.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.func == FUNC_REQUEST) |=> item_stall)
		else $error("request accepted but block not busy");

	// A new result follows a busy cycle.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without work");

endmodule

bind matrix_add_sub_mul mas_chk u_mas_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the matrix add/subtract/multiply block.
module testbench;
	import mas_pkg::*;

	localparam int                 RUN_LIMIT     = 1_000_000;
	localparam int                 ITEM_TARGET   = 1650;
	localparam int                 SETTLE_CYCLES = 24;
	localparam int                 DRAIN_CYCLES  = 40;
	localparam int                 LONG_HOLD     = 400;
	localparam int                 MAX_DIM       = MAX_DIM_DEF;
	localparam logic [1:0]         FUNC_UNUSED   = 2'd3;
	localparam logic [1:0]         OP_UNUSED     = 2'd3;
	localparam logic signed [15:0] ELEM_MIN      = 16'sh8000;
	localparam logic signed [15:0] ELEM_MAX      = 16'sh7FFF;
	localparam logic signed [15:0] ELEM_NEG_ONE  = 16'shFFFF;

	// Shadow copy of both element stores and the registers; predicts each requested
	// element and checks the block's results against them in order.
	class element_checker;
		logic signed [15:0] store_a [16][16];
		logic signed [15:0] store_b [16][16];
		cfg_t               regs;
		result_t            expected_elements [$];
		int unsigned        failures;
		int unsigned        checked;
		int unsigned        loads;
		int unsigned        requests;
		int unsigned        status_count [3];

		function new();
			regs = CFG_RESET;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_OP_MODE: regs.op_mode = data[1:0];
				REG_A_ROWS:  regs.a_rows  = data[4:0];
				REG_A_COLS:  regs.a_cols  = data[4:0];
				REG_B_ROWS:  regs.b_rows  = data[4:0];
				REG_B_COLS:  regs.b_cols  = data[4:0];
				default: ;
			endcase
		endfunction

		function bit usable(logic [4:0] d);
			return d != 5'd0 && int'(d) <= MAX_DIM && int'(d) <= STORE_LIM;
		endfunction

		// Dimension errors win over position errors.
		function logic [1:0] element_status(logic [3:0] row, logic [3:0] col);
			logic [4:0] res_rows;
			logic [4:0] res_cols;
			if (!usable(regs.a_rows) || !usable(regs.a_cols) ||
			    !usable(regs.b_rows) || !usable(regs.b_cols))
				return STAT_DIM;
			case (regs.op_mode)
				OP_ADD, OP_SUB: begin
					if (regs.a_rows != regs.b_rows || regs.a_cols != regs.b_cols)
						return STAT_DIM;
					res_rows = regs.a_rows;
					res_cols = regs.a_cols;
				end
				OP_MUL: begin
					if (regs.a_cols != regs.b_rows)
						return STAT_DIM;
					res_rows = regs.a_rows;
					res_cols = regs.b_cols;
				end
				default: return STAT_DIM;
			endcase
			if ({1'b0, row} >= res_rows || {1'b0, col} >= res_cols)
				return STAT_POS;
			return STAT_OK;
		endfunction

		function result_t compute_element(item_t it);
			result_t r;
			longint  acc;
			acc       = 0;
			r.out_row = it.row;
			r.out_col = it.col;
			r.status  = element_status(it.row, it.col);
			if (r.status == STAT_OK) begin
				case (regs.op_mode)
					OP_ADD: acc = longint'(store_a[it.row][it.col]) +
					              longint'(store_b[it.row][it.col]);
					OP_SUB: acc = longint'(store_a[it.row][it.col]) -
					              longint'(store_b[it.row][it.col]);
					default: begin
						for (int k = 0; k < int'(regs.a_cols); k++)
							acc += longint'(store_a[it.row][k]) * longint'(store_b[k][it.col]);
					end
				endcase
			end
			r.result_value = 36'(acc);
			return r;
		endfunction

		function void note_item(item_t it);
			case (it.func)
				FUNC_LOAD_A: begin
					store_a[it.row][it.col] = it.value;
					loads++;
				end
				FUNC_LOAD_B: begin
					store_b[it.row][it.col] = it.value;
					loads++;
				end
				FUNC_REQUEST: begin
					expected_elements.push_back(compute_element(it));
					requests++;
				end
				default: ;
			endcase
		endfunction

		function void report_field(string field, logic signed [35:0] want,
		                           logic signed [35:0] got);
			failures++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_elements.size() == 0) begin
				failures++;
				$display("%0t: result with nothing expected, expected none, %s",
				         $time, "actual (row,col) value status:");
				$display("    (%0d,%0d) %0d status %0d",
				         got.out_row, got.out_col, got.result_value, got.status);
				return;
			end
			want = expected_elements.pop_front();
			checked++;
			if (want.status <= STAT_POS)
				status_count[want.status]++;
			if (got.out_row !== want.out_row)
				report_field("out_row", want.out_row, got.out_row);
			if (got.out_col !== want.out_col)
				report_field("out_col", want.out_col, got.out_col);
			if (got.result_value !== want.result_value)
				report_field("result_value", want.result_value, got.result_value);
			if (got.status !== want.status)
				report_field("status", want.status, got.status);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;

	element_checker sb = new();

	// Stimulus bookkeeping: which elements have been loaded since reset. A request
	// that would read an element not yet loaded gets its missing loads sent first.
	bit          a_written [16][16];
	bit          b_written [16][16];
	int unsigned items_sent;
	int unsigned phases_run;
	int unsigned holds_done;
	int unsigned calm_left;
	int unsigned cycle_count;
	bit          long_hold_req;

	matrix_add_sub_mul u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sample both channels at the clock edge, before the edge's own updates land,
	// so each transaction is seen exactly once and in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached, %0d results still expected",
			         $time, RUN_LIMIT, sb.expected_elements.size());
			$display("** matrix_add_sub_mul: FAILED **");
			$finish;
		end
	end

	// Result side: stretches of free flow, short stalls and a few long ones. When the
	// stimulus asks for it, hold off for a long fixed stretch so the block backs up.
	initial begin : result_sink
		int unsigned seg;
		int unsigned len;
		result_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
				holds_done++;
			end else begin
				seg = $urandom_range(0, 99);
				if (seg < 45) begin
					result_stall <= 1'b0;
					len = $urandom_range(1, 30);
				end else if (seg < 55) begin
					result_stall <= 1'b0;
					len = $urandom_range(60, 150);
				end else if (seg < 92) begin
					result_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					result_stall <= 1'b1;
					len = $urandom_range(15, 60);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// Gap after each input transaction: mostly none or short, a few long, and now
	// and then a calm stretch with no gaps at all.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return ELEM_MIN;
			1:       return ELEM_MAX;
			2:       return '0;
			3:       return ELEM_NEG_ONE;
			default: return 16'($urandom);
		endcase
	endfunction

	// Index inside a usable dimension, anywhere when the dimension is unusable.
	function automatic logic [3:0] pick_index(logic [4:0] limit);
		if (limit >= 5'd1 && limit <= 5'd16)
			return 4'($urandom_range(0, int'(limit) - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [4:0] pick_dim();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 5'($urandom_range(1, 4));
		if (r < 92)
			return 5'($urandom_range(5, 15));
		return 5'd16;
	endfunction

	// Offer one transaction and hold it until accepted, then idle for any gap that idle_len picks.
	task automatic send_item(input item_t it);
		int unsigned gap;
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (it.func != FUNC_UNUSED)
			items_sent++;
		gap = idle_len();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_element(input logic [1:0] which, input logic [3:0] row,
	                            input logic [3:0] col, input logic signed [15:0] value);
		item_t it;
		it.func  = which;
		it.row   = row;
		it.col   = col;
		it.value = value;
		send_item(it);
		if (which == FUNC_LOAD_A)
			a_written[row][col] = 1'b1;
		else
			b_written[row][col] = 1'b1;
	endtask

	// Fill in whatever the request will read, then send the request itself.
	task automatic request_element(input logic [3:0] row, input logic [3:0] col);
		item_t it;
		if (sb.element_status(row, col) == STAT_OK) begin
			if (sb.regs.op_mode == OP_MUL) begin
				for (int k = 0; k < int'(sb.regs.a_cols); k++) begin
					if (!a_written[row][k])
						load_element(FUNC_LOAD_A, row, 4'(k), rand_value());
					if (!b_written[k][col])
						load_element(FUNC_LOAD_B, 4'(k), col, rand_value());
				end
			end else begin
				if (!a_written[row][col])
					load_element(FUNC_LOAD_A, row, col, rand_value());
				if (!b_written[row][col])
					load_element(FUNC_LOAD_B, row, col, rand_value());
			end
		end
		it.func  = FUNC_REQUEST;
		it.row   = row;
		it.col   = col;
		it.value = 16'($urandom);
		send_item(it);
	endtask

	task automatic send_noise();
		item_t it;
		it.func  = FUNC_UNUSED;
		it.row   = 4'($urandom);
		it.col   = 4'($urandom);
		it.value = 16'($urandom);
		send_item(it);
	endtask

	// Drop valid, drain every expected result, then give trailing loads time to land.
	// The extra edge lets the sampler note a transaction taken at the current edge.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_elements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One write transaction: setup cycle, then access until pready. psel stays up
	// between back-to-back writes; the caller drops it.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic apply_config(input logic [1:0] op, input logic [4:0] ar,
	                            input logic [4:0] ac, input logic [4:0] br,
	                            input logic [4:0] bc);
		settle();
		reg_write(REG_OP_MODE, 32'(op));
		reg_write(REG_A_ROWS, 32'(ar));
		reg_write(REG_A_COLS, 32'(ac));
		reg_write(REG_B_ROWS, 32'(br));
		reg_write(REG_B_COLS, 32'(bc));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		phases_run++;
	endtask

	// Mostly settings whose dimensions fit, with some broken ones mixed in.
	task automatic random_config();
		logic [1:0]  op;
		logic [4:0]  dims [4];
		int unsigned r;
		r = $urandom_range(0, 99);
		foreach (dims[i])
			dims[i] = pick_dim();
		op = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
		if (r < 40) begin
			dims[2] = dims[0];
			dims[3] = dims[1];
		end else if (r < 85) begin
			op      = OP_MUL;
			dims[2] = dims[1];
		end else if (r < 90) begin
			op = OP_UNUSED;
		end else if (r < 95) begin
			op = 2'($urandom_range(0, 2));
			dims[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 5'd0
			                                                  : 5'($urandom_range(17, 31));
		end else begin
			op = 2'($urandom_range(0, 2));
		end
		apply_config(op, dims[0], dims[1], dims[2], dims[3]);
	endtask

	task automatic run_phase(input int unsigned count);
		logic [4:0]  res_rows;
		logic [4:0]  res_cols;
		int unsigned pick;
		res_rows = sb.regs.a_rows;
		res_cols = (sb.regs.op_mode == OP_MUL) ? sb.regs.b_cols : sb.regs.a_cols;
		repeat (count) begin
			if (items_sent >= ITEM_TARGET)
				break;
			pick = $urandom_range(0, 99);
			if (pick < 50)
				request_element(pick_index(res_rows), pick_index(res_cols));
			else if (pick < 70)
				load_element($urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A,
				             4'($urandom), 4'($urandom), rand_value());
			else if (pick < 92)
				request_element(4'($urandom), 4'($urandom));
			else
				send_noise();
		end
	endtask

	initial begin
		// Drive every input to a known value before reset releases.
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		item_valid = 1'b0;
		item       = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, add on 1x1: extreme sums, out-of-range positions, an unused
		// function code, and loads at the far corner of the store.
		load_element(FUNC_LOAD_A, 4'd0, 4'd0, ELEM_MAX);
		load_element(FUNC_LOAD_B, 4'd0, 4'd0, ELEM_MAX);
		request_element(4'd0, 4'd0);
		request_element(4'd0, 4'd1);
		request_element(4'd1, 4'd0);
		send_noise();
		load_element(FUNC_LOAD_A, 4'd15, 4'd15, ELEM_MIN);
		load_element(FUNC_LOAD_B, 4'd15, 4'd15, ELEM_MAX);

		// Subtract at the largest size.
		apply_config(OP_SUB, 5'd16, 5'd16, 5'd16, 5'd16);
		request_element(4'd15, 4'd15);
		request_element(4'd0, 4'd0);

		// Multiply with a single inner term, then with inner dimensions that differ.
		apply_config(OP_MUL, 5'd16, 5'd1, 5'd1, 5'd16);
		load_element(FUNC_LOAD_A, 4'd15, 4'd0, ELEM_MIN);
		load_element(FUNC_LOAD_B, 4'd0, 4'd15, ELEM_MIN);
		request_element(4'd15, 4'd15);
		apply_config(OP_MUL, 5'd16, 5'd1, 5'd2, 5'd16);
		request_element(4'd0, 4'd0);

		// Unusable settings: unused operation, zero and oversize dimensions, and a
		// dimension error that also sits outside the result.
		apply_config(OP_UNUSED, 5'd1, 5'd1, 5'd1, 5'd1);
		request_element(4'd0, 4'd0);
		apply_config(OP_ADD, 5'd0, 5'd1, 5'd1, 5'd1);
		request_element(4'd0, 4'd0);
		apply_config(OP_ADD, 5'd31, 5'd17, 5'd1, 5'd1);
		request_element(4'd0, 4'd0);
		apply_config(OP_ADD, 5'd2, 5'd1, 5'd1, 5'd1);
		request_element(4'd15, 4'd15);

		// Widest dot product: sixteen terms of the most negative element squared.
		apply_config(OP_MUL, 5'd16, 5'd16, 5'd16, 5'd16);
		for (int k = 0; k < 16; k++) begin
			load_element(FUNC_LOAD_A, 4'd0, 4'(k), ELEM_MIN);
			load_element(FUNC_LOAD_B, 4'(k), 4'd0, ELEM_MIN);
		end
		request_element(4'd0, 4'd0);

		// Random phases; once in every ten phases the result side holds off for a long
		// stretch while items keep coming.
		while (items_sent < ITEM_TARGET) begin
			random_config();
			if (phases_run % 10 == 3)
				long_hold_req = 1'b1;
			run_phase($urandom_range(30, 120));
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_elements.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d transactions: %0d loads, %0d requests",
		         items_sent, sb.loads, sb.requests);
		$display("(%0d ok, %0d dimension, %0d position) over %0d register settings,",
		         sb.status_count[STAT_OK], sb.status_count[STAT_DIM],
		         sb.status_count[STAT_POS], phases_run);
		$display("%0d long result hold-offs; %0d results checked", holds_done, sb.checked);
		if (sb.failures == 0 && sb.expected_elements.size() == 0) begin
			$display("** matrix_add_sub_mul: PASSED **");
		end else begin
			$display("** matrix_add_sub_mul: FAILED **");
		end
		$finish;
	end

endmodule
